// File: hw/rtl/sbrcu_pkg.sv
package sbrcu_pkg;

  // Field widths of one command word and one response word.
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 8;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned BUF_DEPTH_DEF = 8192;
  localparam int unsigned NUM_BANKS_DEF = 4;

  // Registers per bank and the 16-bit buffer pointer formed by two of them.
  localparam int unsigned BANK_REGS = 32;
  localparam int unsigned PTR_W     = 16;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Command opcodes as they arrive on the link.
  typedef enum logic [OP_W-1:0] {
    OP_REG_RD  = 3'd0,
    OP_REG_WR  = 3'd1,
    OP_BIT_SET = 3'd2,
    OP_BIT_CLR = 3'd3,
    OP_BUF_RD  = 3'd4,
    OP_BUF_WR  = 3'd5,
    OP_SYS_RST = 3'd6
  } op_e;

  // Classified command, as the back end sees it.
  typedef enum logic [2:0] {
    K_REG_READ,
    K_REG_WRITE,
    K_BIT_SET,
    K_BIT_CLR,
    K_BUF_READ,
    K_BUF_WRITE,
    K_SYS_RESET,
    K_NOP
  } cmd_kind_e;

  // Register addresses with a fixed role.
  localparam logic [ADDR_W-1:0] ADDR_RD_LO    = 5'h00;
  localparam logic [ADDR_W-1:0] ADDR_RD_HI    = 5'h01;
  localparam logic [ADDR_W-1:0] ADDR_WR_LO    = 5'h02;
  localparam logic [ADDR_W-1:0] ADDR_WR_HI    = 5'h03;
  localparam logic [ADDR_W-1:0] PTR_SLOTS     = 5'h04;
  localparam logic [ADDR_W-1:0] COMMON_FIRST  = 5'h1b;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_EN   = 5'h1b;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_FLAG = 5'h1c;
  localparam logic [ADDR_W-1:0] ADDR_STATUS   = 5'h1d;
  localparam logic [ADDR_W-1:0] ADDR_CTRL2    = 5'h1e;
  localparam logic [ADDR_W-1:0] ADDR_CTRL1    = 5'h1f;

  localparam logic [DATA_W-1:0] READY_BIT    = 8'h01;
  localparam int unsigned       AUTO_INC_POS = 7;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] data;
    logic              common;    // address is one of the bank-independent registers
    logic              ptr_slot;  // address is a pointer register slot in bank 0
  } cmd_t;

endpackage

// File: hw/rtl/sbrcu_if.sv
interface sbrcu_cmd_if import sbrcu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] data;

  modport source (output valid, op, reg_addr, data, input ready);
  modport sink (input valid, op, reg_addr, data, output ready);
endinterface

interface sbrcu_rsp_if import sbrcu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: hw/rtl/sbrcu_ram.sv
module sbrcu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/sbrcu_front.sv
module sbrcu_front import sbrcu_pkg::*; (
  sbrcu_cmd_if.sink cmd_i,
  input  logic      full_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  cmd_kind_e kind;

  always_comb begin
    case (cmd_i.op)
      OP_REG_RD:  kind = K_REG_READ;
      OP_REG_WR:  kind = K_REG_WRITE;
      OP_BIT_SET: kind = K_BIT_SET;
      OP_BIT_CLR: kind = K_BIT_CLR;
      OP_BUF_RD:  kind = K_BUF_READ;
      OP_BUF_WR:  kind = K_BUF_WRITE;
      OP_SYS_RST: kind = K_SYS_RESET;
      default:    kind = K_NOP;
    endcase
  end

  assign cmd_i.ready    = ~full_i;
  assign push_o         = cmd_i.valid & ~full_i;
  assign cmd_o.kind     = kind;
  assign cmd_o.reg_addr = cmd_i.reg_addr;
  assign cmd_o.data     = cmd_i.data;
  assign cmd_o.common   = (cmd_i.reg_addr >= COMMON_FIRST);
  assign cmd_o.ptr_slot = (cmd_i.reg_addr < PTR_SLOTS);

endmodule

// File: hw/rtl/sbrcu_queue.sv
module sbrcu_queue import sbrcu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic vld_o,
  output cmd_t cmd_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign cmd_o  = slot_q[rd_ptr_q];

endmodule

// File: hw/rtl/sbrcu_back.sv
module sbrcu_back import sbrcu_pkg::*; #(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF,
  parameter int unsigned NUM_BANKS = NUM_BANKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  sbrcu_rsp_if.source rsp_o
);

  localparam int unsigned RF_DEPTH = NUM_BANKS * BANK_REGS;
  localparam int unsigned RF_AW    = $clog2(RF_DEPTH);
  localparam int unsigned BA_W     = $clog2(BUF_DEPTH);

  // Pointer reduction modulo the buffer depth: q = (p * RECIP) >> RECIP_SH is
  // exact for every 16-bit pointer, then a = p - q * BUF_DEPTH.
  localparam int unsigned       RECIP_SH = 32;
  localparam longint unsigned   RECIP    = ((64'd1 << RECIP_SH) + 64'(BUF_DEPTH) - 64'd1) /
                                           64'(BUF_DEPTH);
  localparam int unsigned       RECIP_W  = $clog2(RECIP + 1);
  localparam int unsigned       PROD_W   = PTR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [PTR_W:0]     DEPTH_V = (PTR_W + 1)'(BUF_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_EXEC     = 5'b00010,
    ST_REG_WAIT = 5'b00100,
    ST_BUF_ADDR = 5'b01000,
    ST_BUF_WAIT = 5'b10000
  } st_e;

  // Pointer and bank-independent registers live in flip-flops.
  typedef struct packed {
    logic [DATA_W-1:0] rd_lo;
    logic [DATA_W-1:0] rd_hi;
    logic [DATA_W-1:0] wr_lo;
    logic [DATA_W-1:0] wr_hi;
    logic [DATA_W-1:0] irq_en;
    logic [DATA_W-1:0] irq_flag;
    logic [DATA_W-1:0] status;
    logic [DATA_W-1:0] ctrl2;
    logic [DATA_W-1:0] ctrl1;
  } spc_regs_t;

  localparam spc_regs_t SPC_RESET = '{status: READY_BIT, default: '0};

  st_e               st_q, st_d;
  cmd_t              cmd_q, cmd_d;
  spc_regs_t         spc_q, spc_d;
  logic [RF_DEPTH-1:0] rf_vld_q, rf_vld_d;
  logic [PTR_W-1:0]  quo_q, quo_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;

  logic [1:0]        bank;
  logic [RF_AW-1:0]  rf_idx;
  logic              special;
  logic [DATA_W-1:0] spc_rd, rf_old;
  logic              rf_we;
  logic [DATA_W-1:0] rf_wdata, rf_rdata;
  logic              buf_we;
  logic [BA_W-1:0]   buf_addr;
  logic [DATA_W-1:0] buf_rdata;
  logic [PTR_W-1:0]  ptr;
  logic [PROD_W-1:0] prod;
  logic [PTR_W-1:0]  ptr_mod;
  logic [BA_W:0]     ptr_inc, ptr_wrap;
  logic [PTR_W-1:0]  ptr_new;
  logic              done;
  logic [DATA_W-1:0] done_val;

  // Bank select reduced modulo the bank count.
  function automatic logic [1:0] bank_of(input logic [1:0] sel);
    case (NUM_BANKS)
      1:       bank_of = 2'd0;
      2:       bank_of = {1'b0, sel[0]};
      3:       bank_of = (sel == 2'd3) ? 2'd0 : sel;
      default: bank_of = sel;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] apply_op(input cmd_kind_e k,
                                                 input logic [DATA_W-1:0] old,
                                                 input logic [DATA_W-1:0] d);
    case (k)
      K_REG_WRITE: apply_op = d;
      K_BIT_SET:   apply_op = old | d;
      K_BIT_CLR:   apply_op = old & ~d;
      default:     apply_op = old;
    endcase
  endfunction

  assign bank    = bank_of(spc_q.ctrl1[1:0]);
  assign rf_idx  = RF_AW'({bank, cmd_q.reg_addr});
  assign special = cmd_q.common | (cmd_q.ptr_slot & (bank == 2'd0));
  assign rf_old  = rf_vld_q[rf_idx] ? rf_rdata : '0;

  always_comb begin
    case (cmd_q.reg_addr)
      ADDR_RD_LO:    spc_rd = spc_q.rd_lo;
      ADDR_RD_HI:    spc_rd = spc_q.rd_hi;
      ADDR_WR_LO:    spc_rd = spc_q.wr_lo;
      ADDR_WR_HI:    spc_rd = spc_q.wr_hi;
      ADDR_IRQ_EN:   spc_rd = spc_q.irq_en;
      ADDR_IRQ_FLAG: spc_rd = spc_q.irq_flag;
      ADDR_STATUS:   spc_rd = spc_q.status;
      ADDR_CTRL2:    spc_rd = spc_q.ctrl2;
      ADDR_CTRL1:    spc_rd = spc_q.ctrl1;
      default:       spc_rd = '0;
    endcase
  end

  // Buffer pointer arithmetic.
  assign ptr      = (cmd_q.kind == K_BUF_READ) ? {spc_q.rd_hi, spc_q.rd_lo}
                                               : {spc_q.wr_hi, spc_q.wr_lo};
  assign prod     = PROD_W'(ptr) * PROD_W'(RECIP_V);
  assign ptr_mod  = ptr - PTR_W'(quo_q * DEPTH_V);
  assign buf_addr = BA_W'(ptr_mod);
  assign ptr_inc  = (BA_W + 1)'(buf_addr) + (BA_W + 1)'(1);
  assign ptr_wrap = (ptr_inc == (BA_W + 1)'(BUF_DEPTH)) ? '0 : ptr_inc;
  assign ptr_new  = PTR_W'(ptr_wrap);

  always_comb begin
    st_d       = st_q;
    cmd_d      = cmd_q;
    spc_d      = spc_q;
    rf_vld_d   = rf_vld_q;
    quo_d      = quo_q;
    out_vld_d  = out_vld_q & ~rsp_o.ready;
    out_data_d = out_data_q;
    pop_o      = 1'b0;
    rf_we      = 1'b0;
    rf_wdata   = cmd_q.data;
    buf_we     = 1'b0;
    done       = 1'b0;
    done_val   = '0;

    case (st_q)
      ST_IDLE: begin
        if (vld_i && (!out_vld_q || rsp_o.ready)) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          st_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q.kind)
          K_REG_READ: begin
            if (special) begin
              done     = 1'b1;
              done_val = spc_rd;
            end else begin
              st_d = ST_REG_WAIT;
            end
          end
          K_REG_WRITE, K_BIT_SET, K_BIT_CLR: begin
            if (special) begin
              done = 1'b1;
              case (cmd_q.reg_addr)
                ADDR_RD_LO:    spc_d.rd_lo    = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                ADDR_RD_HI:    spc_d.rd_hi    = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                ADDR_WR_LO:    spc_d.wr_lo    = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                ADDR_WR_HI:    spc_d.wr_hi    = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                ADDR_IRQ_EN:   spc_d.irq_en   = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                ADDR_IRQ_FLAG: spc_d.irq_flag = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                ADDR_STATUS:   spc_d.status   = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                ADDR_CTRL2:    spc_d.ctrl2    = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                ADDR_CTRL1:    spc_d.ctrl1    = apply_op(cmd_q.kind, spc_rd, cmd_q.data);
                default:       spc_d          = spc_q;
              endcase
            end else if (cmd_q.kind == K_REG_WRITE) begin
              rf_we            = 1'b1;
              rf_vld_d[rf_idx] = 1'b1;
              done             = 1'b1;
            end else begin
              st_d = ST_REG_WAIT;
            end
          end
          K_BUF_READ, K_BUF_WRITE: begin
            quo_d = PTR_W'(prod >> RECIP_SH);
            st_d  = ST_BUF_ADDR;
          end
          K_SYS_RESET: begin
            spc_d    = SPC_RESET;
            rf_vld_d = '0;
            done     = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      ST_REG_WAIT: begin
        done = 1'b1;
        if (cmd_q.kind == K_REG_READ) begin
          done_val = rf_old;
        end else begin
          rf_we            = 1'b1;
          rf_wdata         = apply_op(cmd_q.kind, rf_old, cmd_q.data);
          rf_vld_d[rf_idx] = 1'b1;
        end
      end
      ST_BUF_ADDR: begin
        if (spc_q.ctrl2[AUTO_INC_POS]) begin
          if (cmd_q.kind == K_BUF_READ) begin
            {spc_d.rd_hi, spc_d.rd_lo} = ptr_new;
          end else begin
            {spc_d.wr_hi, spc_d.wr_lo} = ptr_new;
          end
        end
        if (cmd_q.kind == K_BUF_WRITE) begin
          buf_we = 1'b1;
          done   = 1'b1;
        end else begin
          st_d = ST_BUF_WAIT;
        end
      end
      ST_BUF_WAIT: begin
        done     = 1'b1;
        done_val = buf_rdata;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (done) begin
      out_vld_d  = 1'b1;
      out_data_d = done_val;
      st_d       = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      spc_q     <= SPC_RESET;
      rf_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      spc_q     <= spc_d;
      rf_vld_q  <= rf_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

  sbrcu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RF_DEPTH)
  ) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .addr_i  (rf_idx),
    .wdata_i (rf_wdata),
    .rdata_o (rf_rdata)
  );

  sbrcu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .addr_i  (buf_addr),
    .wdata_i (cmd_q.data),
    .rdata_o (buf_rdata)
  );

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.read_data = out_data_q;

endmodule

// File: hw/rtl/spi_banked_register_command_unit.sv
// Banked register and buffer command unit, device side of a SPI register link.
// The cmd_i channel carries one decoded command word per handshake (opcode,
// 5-bit register address, data byte); the rsp_o channel returns exactly one
// response word per command, holding the byte read by a register or buffer
// read and zero for every other command. Both use valid/ready; a word moves
// at a rising edge with valid and ready high.
// A command taken from the queue moves the back end from idle to an execute
// state, which completes accesses to the pointer and common registers, plain
// writes to banked registers and reset or unused opcodes; banked register reads
// and bit set and clear on banked registers go on to a register wait state,
// buffer writes to a buffer address state, and buffer reads through that state
// to a buffer wait state. The back end executes one command at a time; the banked
// register file and the buffer each sit behind a single registered-read RAM
// port, and bit set and clear on a banked register read it before writing it back.
// A two-word command queue lets cmd_i keep accepting while rsp_o is stalled;
// when rsp_o stalls, the back end holds the next command in the queue until
// the pending response word is taken, and cmd_i drops ready once the queue fills.
// Reset clears all registers except the ready bit of the status register and
// is ready to accept at once; the buffer contents are undefined until written.
module spi_banked_register_command_unit import sbrcu_pkg::*; #(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF,
  parameter int unsigned NUM_BANKS = NUM_BANKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbrcu_cmd_if.sink   cmd_i,
  sbrcu_rsp_if.source rsp_o
);

  // Front end to queue.
  logic push;
  logic full;
  cmd_t push_cmd;

  // Queue to back end.
  logic pop;
  logic head_vld;
  cmd_t head_cmd;

  // The front end decodes the opcode and flags the address classes that do
  // not depend on the bank select.
  sbrcu_front u_front (
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  sbrcu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (head_vld),
    .cmd_o  (head_cmd)
  );

  // The back end resolves the bank, owns the register file and the buffer,
  // and drives the response register.
  sbrcu_back #(
    .BUF_DEPTH (BUF_DEPTH),
    .NUM_BANKS (NUM_BANKS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (head_vld),
    .cmd_i  (head_cmd),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule

// File: sim/spi_banked_register_command_unit_tb.sv
`timescale 1ns / 100ps

module spi_banked_register_command_unit_tb import sbrcu_pkg::*;;

  // Sizes of the instance under test; the buffer size also sets the pointer wrap.
  localparam int unsigned BUF_DEPTH = BUF_DEPTH_DEF;
  localparam int unsigned NUM_BANKS = NUM_BANKS_DEF;

  // Opcode 7 has no meaning on the link. It must change nothing and answer zero.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // Random command words to send after the directed table, and the point from
  // which both sides stop idling.
  localparam int unsigned RANDOM_WORDS = 610;
  localparam int unsigned CALM_FROM    = 525;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned DRAIN_AT     = 350;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic clk_i;
  logic rst_ni;

  sbrcu_cmd_if cmd ();
  sbrcu_rsp_if rsp ();

  spi_banked_register_command_unit #(
    .BUF_DEPTH(BUF_DEPTH),
    .NUM_BANKS(NUM_BANKS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  // One row of the directed table. When pinned is set, the response byte is
  // the one typed into the row; otherwise it comes from the shadow device.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              pinned;
    logic [DATA_W-1:0] want;
  } step_t;

  localparam int unsigned DIRECTED_LEN = 25;

  // The directed walk: reset values, the write pointer at its top value so the
  // first buffer write lands on the last entry and the pointer wraps to zero,
  // the read pointer doing the same, a switch to the highest bank, bit set and
  // clear, a common register seen from a banked view, the unused opcode, the
  // reset command, and a buffer read with auto-increment off.
  localparam step_t DIRECTED [DIRECTED_LEN] = '{
    '{OP_REG_RD,  ADDR_STATUS,   8'h00, 1'b1, 8'h01},
    '{OP_REG_RD,  ADDR_CTRL1,    8'h00, 1'b1, 8'h00},
    '{OP_REG_RD,  ADDR_RD_LO,    8'hff, 1'b1, 8'h00},
    '{OP_REG_WR,  ADDR_CTRL2,    8'h80, 1'b1, 8'h00},
    '{OP_REG_WR,  ADDR_WR_LO,    8'hff, 1'b1, 8'h00},
    '{OP_REG_WR,  ADDR_WR_HI,    8'hff, 1'b1, 8'h00},
    '{OP_BUF_WR,  5'h00,         8'ha5, 1'b1, 8'h00},
    '{OP_BUF_WR,  5'h1f,         8'h3a, 1'b1, 8'h00},
    '{OP_REG_RD,  ADDR_WR_LO,    8'h00, 1'b0, 8'h00},
    '{OP_REG_WR,  ADDR_RD_LO,    8'hff, 1'b1, 8'h00},
    '{OP_REG_WR,  ADDR_RD_HI,    8'hff, 1'b1, 8'h00},
    '{OP_BUF_RD,  5'h1f,         8'h00, 1'b0, 8'h00},
    '{OP_BUF_RD,  5'h0a,         8'hff, 1'b0, 8'h00},
    '{OP_BIT_SET, ADDR_CTRL1,    8'h03, 1'b1, 8'h00},
    '{OP_REG_WR,  5'h05,         8'h7a, 1'b1, 8'h00},
    '{OP_BIT_CLR, 5'h05,         8'h0f, 1'b1, 8'h00},
    '{OP_REG_RD,  5'h05,         8'h00, 1'b0, 8'h00},
    '{OP_REG_RD,  ADDR_STATUS,   8'h00, 1'b1, 8'h01},
    '{OP_BIT_CLR, ADDR_CTRL1,    8'hff, 1'b1, 8'h00},
    '{OP_REG_RD,  5'h05,         8'h00, 1'b1, 8'h00},
    '{OP_UNUSED,  5'h1f,         8'hff, 1'b1, 8'h00},
    '{OP_REG_WR,  ADDR_IRQ_FLAG, 8'h40, 1'b1, 8'h00},
    '{OP_SYS_RST, 5'h00,         8'hff, 1'b1, 8'h00},
    '{OP_REG_RD,  ADDR_IRQ_FLAG, 8'h00, 1'b1, 8'h00},
    '{OP_BUF_RD,  5'h1e,         8'h00, 1'b0, 8'h00}
  };

  // Shadow copy of the device: four banks of registers, the buffer, and a
  // record of which buffer entries hold data so that no read ever lands on
  // an entry that was never written.
  logic [DATA_W-1:0] regs [4*BANK_REGS];
  logic [DATA_W-1:0] buf_mem [BUF_DEPTH];
  bit                buf_written [BUF_DEPTH];

  // Response bytes still owed by the block, oldest first.
  logic [DATA_W-1:0] expected_bytes [$];

  int unsigned random_sent;
  int unsigned mismatches;
  int unsigned responses_seen;
  int unsigned op_seen [8];
  bit          calm;
  bit          hold_off_req;

  // Register clear as done by reset and by the reset command: everything goes
  // to zero except the ready flag in the status register.
  function automatic void clear_regs();
    foreach (regs[i]) regs[i] = '0;
    regs[ADDR_STATUS] = READY_BIT;
  endfunction

  // Common registers sit in the bank-0 slots; everything else goes to the bank
  // picked by the low two bits of the control register, folded by the number
  // of banks that the instance has.
  function automatic int unsigned reg_slot(input logic [ADDR_W-1:0] addr);
    int unsigned bank;
    if (addr >= COMMON_FIRST) return addr;
    bank = int'(regs[ADDR_CTRL1][1:0]) % NUM_BANKS;
    return bank * BANK_REGS + addr;
  endfunction

  // Buffer entry addressed by the pointer pair starting at lo. With
  // auto-increment on, the pair is written back one ahead, wrapping at the
  // buffer size.
  function automatic int unsigned claim_pointer(input int unsigned lo);
    int unsigned entry;
    int unsigned nxt;
    entry = {regs[lo+1], regs[lo]} % BUF_DEPTH;
    if (regs[ADDR_CTRL2][AUTO_INC_POS]) begin
      nxt = (entry + 1) % BUF_DEPTH;
      regs[lo]   = nxt[7:0];
      regs[lo+1] = nxt[15:8];
    end
    return entry;
  endfunction

  // Runs one command word against the shadow device and returns the byte the
  // block has to answer with.
  function automatic logic [DATA_W-1:0] execute_command(input logic [OP_W-1:0] op,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    int unsigned       slot;
    int unsigned       entry;
    rd = '0;
    case (op)
      OP_REG_RD: begin
        rd = regs[reg_slot(addr)];
      end
      OP_REG_WR: begin
        regs[reg_slot(addr)] = data;
      end
      OP_BIT_SET: begin
        slot = reg_slot(addr);
        regs[slot] = regs[slot] | data;
      end
      OP_BIT_CLR: begin
        slot = reg_slot(addr);
        regs[slot] = regs[slot] & ~data;
      end
      OP_BUF_RD: begin
        entry = claim_pointer(ADDR_RD_LO);
        rd = buf_mem[entry];
      end
      OP_BUF_WR: begin
        entry = claim_pointer(ADDR_WR_LO);
        buf_mem[entry]     = data;
        buf_written[entry] = 1'b1;
      end
      OP_SYS_RST: begin
        clear_regs();
      end
      default: begin
      end
    endcase
    return rd;
  endfunction

  // Offers one command word, possibly after a random gap, and waits for the
  // handshake. The shadow device is updated at the very edge where the word
  // is taken, so the next word is always built on up-to-date state.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data, input logic pinned,
                           input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    cmd.valid    <= 1'b1;
    cmd.op       <= op;
    cmd.reg_addr <= addr;
    cmd.data     <= data;
    do @(posedge clk_i); while (!cmd.ready);
    predicted = execute_command(op, addr, data);
    expected_bytes.push_back(pinned ? want : predicted);
    op_seen[op]++;
  endtask

  // Random-phase sender. A buffer read whose entry was never written is turned
  // into a register read, since such a read has no defined answer.
  task automatic issue(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                       input logic [DATA_W-1:0] data);
    logic [OP_W-1:0] safe_op;
    safe_op = op;
    if (op == OP_BUF_RD && !buf_written[{regs[ADDR_RD_HI], regs[ADDR_RD_LO]} % BUF_DEPTH])
      safe_op = OP_REG_RD;
    if (safe_op != OP_UNUSED) random_sent++;
    send_word(safe_op, addr, data, 1'b0, '0);
  endtask

  // A well-formed buffer transfer with random content: select bank 0, set or
  // clear auto-increment, load the write pointer, write a short run of bytes,
  // point the read pointer at the same start (sometimes through an alias in
  // the upper pointer bits) and read the run back.
  task automatic run_buffer_burst();
    logic [15:0] start;
    logic [15:0] rd_start;
    int unsigned n;
    bit          auto_inc;
    n = $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0: start = 16'h1fff - 16'($urandom_range(0, 4));
      1: start = 16'hffff - 16'($urandom_range(0, 4));
      2: start = 16'($urandom_range(0, 63));
      default: start = 16'($urandom);
    endcase
    auto_inc = ($urandom_range(0, 4) != 0);
    issue(OP_REG_WR, ADDR_CTRL1, {6'($urandom), 2'b00});
    if ($urandom_range(0, 1) == 0)
      issue(OP_REG_WR, ADDR_CTRL2, {auto_inc, 7'($urandom)});
    else if (auto_inc)
      issue(OP_BIT_SET, ADDR_CTRL2, 8'h80);
    else
      issue(OP_BIT_CLR, ADDR_CTRL2, 8'h80);
    issue(OP_REG_WR, ADDR_WR_LO, start[7:0]);
    issue(OP_REG_WR, ADDR_WR_HI, start[15:8]);
    repeat (n) issue(OP_BUF_WR, 5'($urandom), 8'($urandom));
    rd_start = start;
    if ($urandom_range(0, 2) == 0) rd_start[15:13] = 3'($urandom);
    issue(OP_REG_WR, ADDR_RD_LO, rd_start[7:0]);
    issue(OP_REG_WR, ADDR_RD_HI, rd_start[15:8]);
    repeat (n) issue(OP_BUF_RD, 5'($urandom), 8'($urandom));
  endtask

  // A handful of fully random words, covering every opcode including the
  // unused one and the reset command, any address and any data.
  task automatic run_noise();
    repeat ($urandom_range(1, 6)) issue(3'($urandom), 5'($urandom), 8'($urandom));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Response side: checks every accepted word against the oldest expectation
  // and then decides on the ready for the next cycle. A long hold-off, asked
  // for by the sender, keeps ready low for a counted stretch so that the
  // command queue fills up and the block stalls its input.
  initial begin
    int unsigned       stall_left;
    int unsigned       hold_left;
    logic [DATA_W-1:0] want;
    stall_left = 0;
    hold_left  = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (rsp.valid && rsp.ready) begin
          responses_seen++;
          if (expected_bytes.size() == 0) begin
            $display("%0t: response word with nothing owed: expected none, got %02h",
                     $time, rsp.read_data);
            mismatches++;
          end else begin
            want = expected_bytes.pop_front();
            if (rsp.read_data !== want) begin
              $display("%0t: read_data mismatch: expected %02h, got %02h",
                       $time, want, rsp.read_data);
              mismatches++;
            end
          end
        end
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          rsp.ready <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          rsp.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 17) - 1;
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("%0t: no word moved for %0d cycles, %0d responses outstanding",
                   $time, quiet, expected_bytes.size());
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Main sequence: reset, the directed table, then the random mix with one
  // long receiver hold-off, one full drain by the sender and a calm tail.
  initial begin
    bit hold_done;
    bit drain_done;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    random_sent  = 0;
    mismatches   = 0;
    clear_regs();
    rst_ni       <= 1'b0;
    cmd.valid    <= 1'b0;
    cmd.op       <= '0;
    cmd.reg_addr <= '0;
    cmd.data     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_LEN; i++)
      send_word(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].data,
                DIRECTED[i].pinned, DIRECTED[i].want);

    while (random_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 6) run_buffer_burst();
      else run_noise();
      if (!hold_done && random_sent >= HOLD_AT) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!drain_done && random_sent >= DRAIN_AT) begin
        // Sender pauses here until the block has answered everything.
        drain_done = 1'b1;
        cmd.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk_i);
      end
      if (random_sent >= CALM_FROM) calm = 1'b1;
    end
    cmd.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d response words: reg rd %0d, wr %0d, set %0d, clr %0d,",
             responses_seen, op_seen[OP_REG_RD], op_seen[OP_REG_WR],
             op_seen[OP_BIT_SET], op_seen[OP_BIT_CLR]);
    $display("buf rd %0d, buf wr %0d, reset cmd %0d, unused op %0d; %0d mismatches",
             op_seen[OP_BUF_RD], op_seen[OP_BUF_WR], op_seen[OP_SYS_RST],
             op_seen[OP_UNUSED], mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sbrcu_pkg.sv
hw/rtl/sbrcu_if.sv
hw/rtl/sbrcu_ram.sv
hw/rtl/sbrcu_front.sv
hw/rtl/sbrcu_queue.sv
hw/rtl/sbrcu_back.sv
hw/rtl/spi_banked_register_command_unit.sv
sim/spi_banked_register_command_unit_tb.sv
